/* design/prqs_pkg.sv */
package prqs_pkg;

	// Field widths of the command and result words
	localparam int CMD_W  = 2;
	localparam int TID_W  = 4;
	localparam int PRIO_W = 3;

	// Input word: cmd, thread_id, prio from bit 0 up, padded to 16 bits
	localparam int S_DATA_W = 16;
	// Output word: switched, next_valid, next_thread, preempted, queue_fault
	localparam int M_DATA_W = 8;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_YIELD    = 2'd1,
		CMD_FINISH   = 2'd2,
		CMD_START    = 2'd3
	} cmd_t;

endpackage

/* design/prqs_link_mem.sv */
// Per-thread next-pointer memory, one write and one registered read per cycle.
// A read that hits the address written in the same cycle returns the new data.
module prqs_link_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	// write port, and read port with write-through bypass
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

/* design/priority_ready_queue_scheduler.sv */
// Hardware thread scheduler with one FIFO ready list per priority level (0 is
// best), linked through a per-thread next pointer, and a bitmap of non-empty
// levels. Commands are schedule, yield, finish and start; each returns exactly
// one result word with the running thread after the command. One command is
// taken every cycle unless a held result stalls stage 1. A result passes the
// input register (prefetched head, tail and link reads), then the state
// update into the output register, which lets the next command enter while
// a result waits to be taken. Priorities >= NUM_LEVELS and thread ids >= NUM_THREADS
// saturate to the largest legal value. Queuing a thread twice is unsupported.
module priority_ready_queue_scheduler #(
	parameter int NUM_LEVELS  = 8,
	parameter int NUM_THREADS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] cmd, [5:2] thread_id, [8:6] prio, [15:9] zero
	input  logic [prqs_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] switched, [1] next_valid, [5:2] next_thread, [6] preempted,
	// [7] queue_fault
	output logic [prqs_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int LW   = $clog2(NUM_LEVELS);
	localparam int TW   = $clog2(NUM_THREADS);
	localparam int TIDW = prqs_pkg::TID_W;

	// input word fields
	prqs_pkg::cmd_t          cmd_in;
	logic [TIDW-1:0]         tid_in;
	logic [prqs_pkg::PRIO_W-1:0] prio_in;
	logic [TW-1:0]           t_in;
	logic [LW-1:0]           p_in;
	logic                    in_fire;
	logic                    fire;

	// stage 1
	logic                    v_s1;
	prqs_pkg::cmd_t          cmd_s1;
	logic [TW-1:0]           t_s1;
	logic [LW-1:0]           p_s1;
	logic [TW-1:0]           head_s1;
	logic [TW-1:0]           tail_s1;
	logic [TW-1:0]           nl_s1;

	// scheduler state
	logic [NUM_LEVELS-1:0]   bitmap_q;
	logic [TW-1:0]           head_q [NUM_LEVELS];
	logic [TW-1:0]           tail_q [NUM_LEVELS];
	logic [TW-1:0]           rthread_q;
	logic                    rvalid_q;
	logic [LW-1:0]           rprio_q;
	logic                    started_q;

	// next state and writes
	logic [NUM_LEVELS-1:0]   bmp_nx;
	logic [NUM_LEVELS-1:0]   fb_bmp;
	logic [LW-1:0]           best;
	logic [TW-1:0]           fb_head;
	logic                    nonempty;
	logic                    is_head;
	logic                    tail_is_t;
	logic                    head_we;
	logic [TW-1:0]           head_wd;
	logic                    tail_we;
	logic                    link_we;
	logic                    head_wr;
	logic                    tail_wr;
	logic [TW-1:0]           rt_nx;
	logic                    rv_nx;
	logic [LW-1:0]           rp_nx;
	logic                    st_nx;
	logic                    pre;
	logic                    flt;
	logic [TW-1:0]           nt;
	logic [TW-1:0]           old_nt;
	logic                    sw;

	// output register
	logic                    m_valid_q;
	logic                    sw_q;
	logic                    nv_q;
	logic [TIDW-1:0]         nt_q;
	logic                    pre_q;
	logic                    flt_q;

	// unpack and saturate the incoming word
	assign cmd_in  = prqs_pkg::cmd_t'(s_tdata[1:0]);
	assign tid_in  = s_tdata[5:2];
	assign prio_in = s_tdata[8:6];
	assign t_in    = (int'(tid_in) >= NUM_THREADS) ? TW'(NUM_THREADS - 1) : TW'(tid_in);
	assign p_in    = (int'(prio_in) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(prio_in);

	// handshake: stage 1 advances whenever the output register is free
	assign fire     = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || fire;
	assign in_fire  = s_tvalid && s_tready;
	assign head_wr  = fire && head_we;
	assign tail_wr  = fire && tail_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload and head/tail prefetch with bypass of the current write
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd_in;
			t_s1   <= t_in;
			p_s1   <= p_in;
			if (head_wr && (p_s1 == p_in)) begin
				head_s1 <= head_wd;
			end else begin
				head_s1 <= head_q[p_in];
			end
			if (tail_wr && (p_s1 == p_in)) begin
				tail_s1 <= t_s1;
			end else begin
				tail_s1 <= tail_q[p_in];
			end
		end
	end

	// next-pointer memory, read at the incoming thread
	prqs_link_mem #(
		.DEPTH (NUM_THREADS),
		.AW    (TW)
	) u_link (
		.clk   (clk),
		.we    (fire && link_we),
		.waddr (tail_s1),
		.wdata (t_s1),
		.re    (in_fire),
		.raddr (t_in),
		.rdata (nl_s1)
	);

	// command decode and state update
	always_comb begin
		nonempty  = bitmap_q[p_s1];
		is_head   = nonempty && (head_s1 == t_s1);
		tail_is_t = (tail_s1 == t_s1);
		bmp_nx    = bitmap_q;
		head_we   = 1'b0;
		head_wd   = t_s1;
		tail_we   = 1'b0;
		link_we   = 1'b0;
		rv_nx     = rvalid_q;
		rt_nx     = rthread_q;
		rp_nx     = rprio_q;
		st_nx     = started_q;
		pre       = 1'b0;
		flt       = 1'b0;

		// bitmap seen by the fallback: finish of a level's last thread empties it
		fb_bmp = bitmap_q;
		if ((cmd_s1 == prqs_pkg::CMD_FINISH) && is_head && tail_is_t) begin
			fb_bmp[p_s1] = 1'b0;
		end

		// priority encoder: lowest set level
		best = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (fb_bmp[i]) begin
				best = LW'(i);
			end
		end
		fb_head = head_q[best];

		case (cmd_s1)
			prqs_pkg::CMD_SCHEDULE: begin
				bmp_nx[p_s1] = 1'b1;
				if (!nonempty) begin
					head_we = 1'b1;
				end else begin
					link_we = 1'b1;
				end
				tail_we = 1'b1;
				if (started_q) begin
					if (!rvalid_q) begin
						rv_nx = 1'b1;
						rt_nx = t_s1;
						rp_nx = p_s1;
					end else if (rprio_q > p_s1) begin
						pre   = 1'b1;
						rv_nx = 1'b1;
						rt_nx = t_s1;
						rp_nx = p_s1;
					end
				end
			end
			prqs_pkg::CMD_YIELD: begin
				if (is_head) begin
					if (!tail_is_t) begin
						link_we = 1'b1;
						tail_we = 1'b1;
						head_we = 1'b1;
						head_wd = nl_s1;
						rv_nx   = 1'b1;
						rt_nx   = nl_s1;
						rp_nx   = p_s1;
					end
				end else begin
					flt = 1'b1;
					if (fb_bmp == '0) begin
						rv_nx = 1'b0;
					end else begin
						rv_nx = 1'b1;
						rt_nx = fb_head;
						rp_nx = best;
					end
				end
			end
			prqs_pkg::CMD_FINISH: begin
				if (is_head && !tail_is_t) begin
					head_we = 1'b1;
					head_wd = nl_s1;
					rv_nx   = 1'b1;
					rt_nx   = nl_s1;
					rp_nx   = p_s1;
				end else begin
					flt    = !is_head;
					bmp_nx = fb_bmp;
					if (fb_bmp == '0) begin
						rv_nx = 1'b0;
					end else begin
						rv_nx = 1'b1;
						rt_nx = fb_head;
						rp_nx = best;
					end
				end
			end
			prqs_pkg::CMD_START: begin
				st_nx = 1'b1;
				if (bitmap_q != '0) begin
					rv_nx = 1'b1;
					rt_nx = fb_head;
					rp_nx = best;
				end
			end
			default: begin
			end
		endcase

		// result fields
		nt     = rv_nx ? rt_nx : '0;
		old_nt = rvalid_q ? rthread_q : '0;
		sw     = (rv_nx != rvalid_q) || (nt != old_nt);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q  <= '0;
			rthread_q <= '0;
			rvalid_q  <= 1'b0;
			rprio_q   <= '0;
			started_q <= 1'b0;
		end else if (fire) begin
			bitmap_q  <= bmp_nx;
			rthread_q <= rt_nx;
			rvalid_q  <= rv_nx;
			rprio_q   <= rp_nx;
			started_q <= st_nx;
		end
	end

	// per-level head and tail registers
	always_ff @(posedge clk) begin
		if (head_wr) begin
			head_q[p_s1] <= head_wd;
		end
		if (tail_wr) begin
			tail_q[p_s1] <= t_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sw_q  <= sw;
			nv_q  <= rv_nx;
			nt_q  <= TIDW'(nt);
			pre_q <= pre;
			flt_q <= flt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {flt_q, pre_q, nt_q, nv_q, sw_q};

endmodule

/* tb/sched_result_checker.sv */
`timescale 1ns / 1ps

// Watches both stream channels of the scheduler, predicts the result word of
// every accepted command word and compares it with the words that come out.
module sched_result_checker
	import prqs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  fail_count,
	output int                  pending
);

	// Result word layout, last member in the lowest bit
	typedef struct packed {
		logic       queue_fault;
		logic       preempted;
		logic [3:0] next_thread;
		logic       next_valid;
		logic       switched;
	} sched_result_t;

	// Predicted scheduler state
	logic [7:0] level_bitmap;
	logic [3:0] level_head [8];
	logic [3:0] level_tail [8];
	logic [3:0] next_link  [16];
	logic [3:0] run_thread;
	logic [2:0] run_prio;
	logic       run_valid;
	logic       started;

	sched_result_t expected_results [$];

	function automatic void run_on(logic [3:0] t, logic [2:0] p);
		run_thread = t;
		run_prio   = p;
		run_valid  = 1'b1;
	endfunction

	// Run the head of the best non-empty level, or go idle
	function automatic void fall_back();
		int best;
		best = 0;
		if (level_bitmap == '0) begin
			run_valid = 1'b0;
		end else begin
			for (int i = 7; i >= 0; i--)
				if (level_bitmap[i])
					best = i;
			run_on(level_head[best], 3'(best));
		end
	endfunction

	function automatic sched_result_t predict_command(cmd_t c, logic [3:0] t, logic [2:0] p);
		sched_result_t r;
		logic          old_valid;
		logic [3:0]    old_thread;
		logic          nonempty;
		logic          at_head;
		r          = '0;
		old_valid  = run_valid;
		old_thread = run_valid ? run_thread : 4'd0;
		nonempty   = level_bitmap[p];
		at_head    = nonempty && level_head[p] == t;
		case (c)
			CMD_SCHEDULE: begin
				if (!nonempty) begin
					level_bitmap[p] = 1'b1;
					level_head[p]   = t;
				end else begin
					next_link[level_tail[p]] = t;
				end
				level_tail[p] = t;
				if (started) begin
					if (!run_valid) begin
						run_on(t, p);
					end else if (run_prio > p) begin
						r.preempted = 1'b1;
						run_on(t, p);
					end
				end
			end
			CMD_YIELD: begin
				if (!at_head) begin
					r.queue_fault = 1'b1;
					fall_back();
				end else if (level_tail[p] != t) begin
					// rotate head to tail, next in line runs
					level_head[p]            = next_link[t];
					next_link[level_tail[p]] = t;
					level_tail[p]            = t;
					run_on(level_head[p], p);
				end
			end
			CMD_FINISH: begin
				if (!at_head) begin
					r.queue_fault = 1'b1;
					fall_back();
				end else if (level_tail[p] == t) begin
					level_bitmap[p] = 1'b0;
					fall_back();
				end else begin
					level_head[p] = next_link[t];
					run_on(level_head[p], p);
				end
			end
			default: begin
				started = 1'b1;
				if (level_bitmap != '0)
					fall_back();
			end
		endcase
		r.next_valid  = run_valid;
		r.next_thread = run_valid ? run_thread : 4'd0;
		r.switched    = (run_valid != old_valid) || (r.next_thread != old_thread);
		return r;
	endfunction

	// Compare result words, then predict from command words
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		sched_result_t got;
		if (!arst_n) begin
			level_bitmap = '0;
			foreach (level_head[i]) begin
				level_head[i] = '0;
				level_tail[i] = '0;
			end
			foreach (next_link[i])
				next_link[i] = '0;
			run_thread = '0;
			run_prio   = '0;
			run_valid  = 1'b0;
			started    = 1'b0;
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = sched_result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("result word %h with no expectation waiting", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.switched !== want.switched) begin
						$error("switched: expected %0d, actual %0d", want.switched, got.switched);
						fail_count++;
					end
					if (got.next_valid !== want.next_valid) begin
						$error("next_valid: expected %0d, actual %0d",
							want.next_valid, got.next_valid);
						fail_count++;
					end
					if (got.next_thread !== want.next_thread) begin
						$error("next_thread: expected %0d, actual %0d",
							want.next_thread, got.next_thread);
						fail_count++;
					end
					if (got.preempted !== want.preempted) begin
						$error("preempted: expected %0d, actual %0d",
							want.preempted, got.preempted);
						fail_count++;
					end
					if (got.queue_fault !== want.queue_fault) begin
						$error("queue_fault: expected %0d, actual %0d",
							want.queue_fault, got.queue_fault);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_command(cmd_t'(s_tdata[1:0]),
					s_tdata[5:2], s_tdata[8:6]));
			pending = expected_results.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import prqs_pkg::*;

	localparam int PHASE_WORDS = 550;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	int                  fail_count;
	int                  pending;

	int tx_idle_pct;
	int rx_idle_pct;

	// Shadow of the ready lists, used only to keep commands well formed
	logic [3:0] ready_list [8][$];
	logic       queued     [16];

	priority_ready_queue_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sched_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	// Receiver stalls at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Present one command word, with random gaps, until it is taken
	task automatic issue_command(cmd_t c, logic [3:0] t, logic [2:0] p);
		case (c)
			CMD_SCHEDULE: begin
				ready_list[p].push_back(t);
				queued[t] = 1'b1;
			end
			CMD_YIELD: begin
				if (ready_list[p].size() > 1 && ready_list[p][0] == t)
					ready_list[p].push_back(ready_list[p].pop_front());
			end
			CMD_FINISH: begin
				if (ready_list[p].size() != 0 && ready_list[p][0] == t) begin
					void'(ready_list[p].pop_front());
					queued[t] = 1'b0;
				end
			end
			default: ;
		endcase
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, p, t, c};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Mostly well-formed queue traffic, some misuse of yield and finish
	task automatic random_command();
		int         roll;
		int         n_free;
		int         lvl;
		logic [3:0] t;
		logic [2:0] p;
		roll   = $urandom_range(0, 99);
		n_free = 0;
		foreach (queued[i])
			if (!queued[i])
				n_free++;
		if (roll < 3) begin
			issue_command(CMD_START, 4'($urandom), 3'($urandom));
		end else if (roll < 13) begin
			issue_command($urandom_range(0, 1) ? CMD_YIELD : CMD_FINISH,
				4'($urandom), 3'($urandom));
		end else if (n_free != 0 && (n_free == 16 || roll < (n_free > 8 ? 60 : 40))) begin
			t = 4'($urandom);
			while (queued[t])
				t = 4'($urandom);
			p = $urandom_range(0, 1) ? 3'($urandom) : 3'($urandom_range(0, 2));
			issue_command(CMD_SCHEDULE, t, p);
		end else begin
			lvl = $urandom_range(0, 7);
			while (ready_list[lvl].size() == 0)
				lvl = $urandom_range(0, 7);
			issue_command($urandom_range(0, 1) ? CMD_YIELD : CMD_FINISH,
				ready_list[lvl][0], 3'(lvl));
		end
	endtask

	// Stop sending and let every outstanding result word drain
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		tx_idle_pct = 38;
		rx_idle_pct = 70;
		foreach (queued[i])
			queued[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: faults on empty levels, queuing before start, preemption,
		// rotation, head mismatch, sole member, last member, repeated start
		issue_command(CMD_YIELD,    4'd0,  3'd0);
		issue_command(CMD_FINISH,   4'd15, 3'd7);
		issue_command(CMD_SCHEDULE, 4'd5,  3'd3);
		issue_command(CMD_SCHEDULE, 4'd15, 3'd7);
		issue_command(CMD_START,    4'd15, 3'd7);
		issue_command(CMD_SCHEDULE, 4'd0,  3'd0);
		issue_command(CMD_SCHEDULE, 4'd9,  3'd0);
		issue_command(CMD_SCHEDULE, 4'd3,  3'd3);
		issue_command(CMD_YIELD,    4'd0,  3'd0);
		issue_command(CMD_YIELD,    4'd5,  3'd7);
		issue_command(CMD_YIELD,    4'd15, 3'd7);
		issue_command(CMD_FINISH,   4'd9,  3'd0);
		issue_command(CMD_FINISH,   4'd0,  3'd0);
		issue_command(CMD_FINISH,   4'd5,  3'd3);
		issue_command(CMD_FINISH,   4'd3,  3'd3);
		issue_command(CMD_FINISH,   4'd15, 3'd7);
		issue_command(CMD_START,    4'd0,  3'd0);
		issue_command(CMD_SCHEDULE, 4'd10, 3'd6);
		issue_command(CMD_START,    4'd6,  3'd5);
		issue_command(CMD_FINISH,   4'd10, 3'd6);
		drain();

		// Random phases: receiver-heavy idling, sender-heavy, then none
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 70 : 0;
			rx_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 38 : 0;
			for (int i = 0; i < PHASE_WORDS; i++)
				random_command();
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
